/* rtl/lcg46_pkg.sv */
// ----------------------------------------------------------------------------
// lcg46_pkg
// Shared types and constants for the modulo 2^46 multiplicative generator.
// ----------------------------------------------------------------------------
package lcg46_pkg;

    localparam int unsigned MOD_W   = 46;
    localparam int unsigned HALF_W  = MOD_W / 2;
    localparam int unsigned SEED_W  = 31;
    localparam int unsigned COUNT_W = 44;
    localparam int unsigned APB_DW  = 64;
    localparam int unsigned APB_AW  = 4;

    localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(314159265);
    localparam logic [MOD_W-1:0]  MULT_RESET = MOD_W'(1220703125);
    // The reset seed is odd, so the reset state is just seed times multiplier.
    localparam logic [MOD_W-1:0]  CUR_RESET  = MOD_W'(64'd314159265 * 64'd1220703125);

    // Register indexes of the configuration port.
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_MULT = 1'b1;

    // Operand pairs for the shared modular multiplier.
    typedef enum logic [1:0] {
        OP_CUR_MULT = 2'd0,
        OP_CUR_PW   = 2'd1,
        OP_PW_PW    = 2'd2
    } t_op_sel;

    typedef struct packed {
        logic    load_jump;
        logic    mul_start;
        t_op_sel op_sel;
        logic    wr_cur;
        logic    wr_pw;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic cnt_zero;
        logic cnt_lsb;
    } t_dp_sts;

endpackage

/* rtl/lcg46_mul.sv */
// ----------------------------------------------------------------------------
// lcg46_mul
// Multi-cycle multiplier modulo 2^46 built on one shared 23x23 multiplier.
// ----------------------------------------------------------------------------
module lcg46_mul
    import lcg46_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MOD_W-1:0] i_a,
    input  logic [MOD_W-1:0] i_b,
    output logic             o_busy,
    output logic             o_done,
    output logic [MOD_W-1:0] o_result
);

    localparam logic [1:0] PH_LL   = 2'd0;
    localparam logic [1:0] PH_HL   = 2'd1;
    localparam logic [1:0] PH_LH   = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_ph;
    logic [MOD_W-1:0]  r_a;
    logic [MOD_W-1:0]  r_b;
    logic [MOD_W-1:0]  r_prod;
    logic [MOD_W-1:0]  r_acc;
    logic [HALF_W-1:0] m_x;
    logic [HALF_W-1:0] m_y;
    logic [MOD_W-1:0]  m_prod;

    // The high-by-high product falls entirely above bit 45 and is never formed.
    always_comb begin
        m_x    = (r_ph == PH_HL) ? r_a[MOD_W-1:HALF_W] : r_a[HALF_W-1:0];
        m_y    = (r_ph == PH_LH) ? r_b[MOD_W-1:HALF_W] : r_b[HALF_W-1:0];
        m_prod = {{HALF_W{1'b0}}, m_x} * {{HALF_W{1'b0}}, m_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_LL;
        end else begin
            r_done <= r_busy && (r_ph == PH_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_LL;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == PH_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_prod <= m_prod;
            if (r_ph == PH_HL) begin
                r_acc <= r_prod;
            end else if (r_ph != PH_LL) begin
                r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

/* rtl/lcg46_dp.sv */
// ----------------------------------------------------------------------------
// lcg46_dp
// Datapath: current value, running power, jump count and output register.
// ----------------------------------------------------------------------------
module lcg46_dp
    import lcg46_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [SEED_W-1:0]  i_seed,
    input  logic [MOD_W-1:0]   i_mult,
    input  logic [COUNT_W-1:0] i_jump_count,
    output logic [MOD_W-1:0]   o_random_value
);

    logic [MOD_W-1:0]   r_cur;
    logic [MOD_W-1:0]   r_pw;
    logic [COUNT_W-1:0] r_cnt;
    logic [MOD_W-1:0]   r_out;
    logic [MOD_W-1:0]   op_a;
    logic [MOD_W-1:0]   op_b;
    logic [MOD_W-1:0]   mul_res;
    logic               mul_busy;
    logic               mul_done;

    always_comb begin
        case (i_cmd.op_sel)
            OP_CUR_PW: begin
                op_a = r_cur;
                op_b = r_pw;
            end
            OP_PW_PW: begin
                op_a = r_pw;
                op_b = r_pw;
            end
            default: begin
                op_a = r_cur;
                op_b = i_mult;
            end
        endcase
    end

    lcg46_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_busy   (mul_busy),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= CUR_RESET;
        end else if (i_cmd.load_jump) begin
            // Forcing bit zero high is the same as adding one to an even seed.
            r_cur <= {{(MOD_W-SEED_W){1'b0}}, i_seed[SEED_W-1:1], 1'b1};
        end else if (i_cmd.wr_cur) begin
            r_cur <= mul_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_jump) begin
            r_pw  <= i_mult;
            r_cnt <= i_jump_count;
        end else if (i_cmd.wr_pw) begin
            r_pw  <= mul_res;
            r_cnt <= {1'b0, r_cnt[COUNT_W-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out <= r_cur;
        end
    end

    assign o_sts.mul_busy = mul_busy;
    assign o_sts.mul_done = mul_done;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_lsb  = r_cnt[0];
    assign o_random_value = r_out;

endmodule

/* rtl/lcg46_ctrl.sv */
// ----------------------------------------------------------------------------
// lcg46_ctrl
// Controller: sequences next steps and square-and-multiply jumps.
// ----------------------------------------------------------------------------
module lcg46_ctrl
    import lcg46_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_req_type,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_JCHK = 6'b000010,
        S_JMUL = 6'b000100,
        S_JSQ  = 6'b001000,
        S_STEP = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        cmd.op_sel = OP_CUR_MULT;
        o_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_req_type) begin
                        cmd.load_jump = 1'b1;
                        n_state       = S_JCHK;
                    end else begin
                        cmd.mul_start = 1'b1;
                        n_state       = S_STEP;
                    end
                end
            end
            S_JCHK: begin
                cmd.mul_start = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_STEP;
                end else if (i_sts.cnt_lsb) begin
                    cmd.op_sel = OP_CUR_PW;
                    n_state    = S_JMUL;
                end else begin
                    cmd.op_sel = OP_PW_PW;
                    n_state    = S_JSQ;
                end
            end
            S_JMUL: begin
                if (i_sts.mul_done) begin
                    cmd.wr_cur    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.op_sel    = OP_PW_PW;
                    n_state       = S_JSQ;
                end
            end
            S_JSQ: begin
                if (i_sts.mul_done) begin
                    cmd.wr_pw = 1'b1;
                    n_state   = S_JCHK;
                end
            end
            S_STEP: begin
                if (i_sts.mul_done) begin
                    cmd.wr_cur = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                // The output register may be refilled in the cycle its word leaves.
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("lcg46_ctrl: ready stayed high after an accepted word");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("lcg46_ctrl: output register overwritten before it was taken");

    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_start |-> !i_sts.mul_busy)
        else $error("lcg46_ctrl: multiply started while the multiplier was busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!i_sts.mul_busy && !i_sts.mul_done))
        else $error("lcg46_ctrl: multiplier active while the controller is idle");
`endif

endmodule

/* rtl/lcg46_random_with_jump_ahead_core.sv */
// ----------------------------------------------------------------------------
// lcg46_random_with_jump_ahead_core
// Multiplicative congruential generator modulo 2^46 with jump-ahead.
// ----------------------------------------------------------------------------
// A request is accepted only when the previous word has been loaded into the output
// register. Each modular multiply runs on the one shared 23x23 multiplier. A jump
// squares once per bit of jump_count up to its highest set bit and multiplies once
// per set bit, then takes one ordinary next step.
// Synchronous active-low reset loads the default seed and multiplier and sets
// the current value to seed times multiplier; no clearing pass is needed.
module lcg46_random_with_jump_ahead_core
    import lcg46_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [COUNT_W-1:0] i_jump_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MOD_W-1:0]   o_random_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [SEED_W-1:0] r_seed;
    logic [MOD_W-1:0]  r_mult;
    logic              reg_idx;
    logic              wr_en;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // Registers sit on 8-byte boundaries; the low address bits are not decoded.
    assign reg_idx = paddr[3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_mult <= MULT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SEED: r_seed <= pwdata[SEED_W-1:0];
                REG_MULT: r_mult <= pwdata[MOD_W-1:0];
                default:  r_seed <= r_seed;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SEED: prdata = {{(APB_DW-SEED_W){1'b0}}, r_seed};
            REG_MULT: prdata = {{(APB_DW-MOD_W){1'b0}}, r_mult};
            default:  prdata = '0;
        endcase
    end

    lcg46_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lcg46_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_seed         (r_seed),
        .i_mult         (r_mult),
        .i_jump_count   (i_jump_count),
        .o_random_value (o_random_value)
    );

endmodule

/* sim/lcg46_random_with_jump_ahead_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcg46_random_with_jump_ahead_core_tb
// Drives next and jump requests into the modulo 2^46 generator under random
// valid/ready idling. An internal generator model predicts each output word,
// and a checker compares every word in order. Seed and multiplier are
// reprogrammed over the APB port between traffic phases, including the extremes.
// ----------------------------------------------------------------------------
module lcg46_random_with_jump_ahead_core_tb
    import lcg46_pkg::*;
();

    localparam logic REQ_NEXT = 1'b0;
    localparam logic REQ_JUMP = 1'b1;

    localparam logic [APB_AW-1:0] ADDR_SEED = {REG_SEED, 3'b000};
    localparam logic [APB_AW-1:0] ADDR_MULT = {REG_MULT, 3'b000};

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = REQ_NEXT;
    logic [COUNT_W-1:0] i_jump_count = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [MOD_W-1:0]   o_random_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Generator model state and its copy of the registers.
    logic [SEED_W-1:0]  gen_seed = SEED_RESET;
    logic [MOD_W-1:0]   gen_mult = MULT_RESET;
    logic [MOD_W-1:0]   gen_value;

    logic [MOD_W-1:0]   expected_values[$];
    logic [MOD_W-1:0]   expected_word;
    int                 error_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 stall_cycles = 0;

    lcg46_random_with_jump_ahead_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_jump_count   (i_jump_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [MOD_W-1:0] mul_mod46(input logic [MOD_W-1:0] a,
                                                   input logic [MOD_W-1:0] b);
        logic [MOD_W-1:0] p;
        // The product is evaluated at 46 bits, which is exactly mod 2^46.
        p = a * b;
        return p;
    endfunction

    function automatic logic [MOD_W-1:0] odd_seed(input logic [SEED_W-1:0] s);
        logic [MOD_W-1:0] v;
        v = MOD_W'(s);
        if (!v[0]) begin
            v = v + 1'b1;
        end
        return v;
    endfunction

    initial gen_value = mul_mod46(odd_seed(SEED_RESET), MULT_RESET);

    // Advances the generator model for one accepted request.
    task automatic predict_word(input logic req, input logic [COUNT_W-1:0] cnt);
        logic [MOD_W-1:0]   pw;
        logic [MOD_W-1:0]   v;
        logic [COUNT_W-1:0] n;
        if (req == REQ_JUMP) begin
            pw = gen_mult;
            v = odd_seed(gen_seed);
            n = cnt;
            while (n != '0) begin
                if (n[0]) begin
                    v = mul_mod46(v, pw);
                end
                pw = mul_mod46(pw, pw);
                n = n >> 1;
            end
            gen_value = v;
        end
        gen_value = mul_mod46(gen_value, gen_mult);
        expected_values.push_back(gen_value);
    endtask

    task automatic send_word(input logic req, input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_jump_count <= cnt;
        do @(posedge i_clk); while (!o_ready);
        predict_word(req, cnt);
    endtask

    // Every request yields a word, so the block is idle once the queue drains.
    task automatic wait_idle;
        i_valid <= 1'b0;
        while (expected_values.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_SEED) begin
            gen_seed = data[SEED_W-1:0];
        end else if (addr == ADDR_MULT) begin
            gen_mult = data[MOD_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Output checker: each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h",
                         $time, o_random_value);
                error_count++;
            end else begin
                expected_word = expected_values.pop_front();
                if (o_random_value !== expected_word) begin
                    $display("%0t: random_value mismatch, expected %h actual %h",
                             $time, expected_word, o_random_value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_reset_state;
        send_word(REQ_NEXT, '0);
        send_word(REQ_NEXT, '0);
        // The count is ignored on a next request.
        send_word(REQ_NEXT, '1);
    endtask

    task automatic test_jump_edges;
        send_word(REQ_JUMP, '0);
        send_word(REQ_JUMP, COUNT_W'(1));
        send_word(REQ_JUMP, '1);
        send_word(REQ_JUMP, {(COUNT_W/2){2'b10}});
        send_word(REQ_JUMP, {(COUNT_W/2){2'b01}});
        send_word(REQ_NEXT, '0);
    endtask

    task automatic test_config_extremes;
        wait_idle();
        // Seed zero is even and becomes one.
        write_reg(ADDR_SEED, '0);
        send_word(REQ_JUMP, '0);
        send_word(REQ_NEXT, '0);
        wait_idle();
        write_reg(ADDR_SEED, APB_DW'({SEED_W{1'b1}}));
        send_word(REQ_JUMP, COUNT_W'(3));
        wait_idle();
        // A new multiplier applies to the held value without a restart.
        write_reg(ADDR_MULT, '0);
        send_word(REQ_NEXT, '0);
        send_word(REQ_JUMP, COUNT_W'(5));
        wait_idle();
        write_reg(ADDR_MULT, APB_DW'({MOD_W{1'b1}}));
        send_word(REQ_JUMP, COUNT_W'(1));
        send_word(REQ_NEXT, '0);
        wait_idle();
        // An even multiplier drives the sequence toward zero.
        write_reg(ADDR_MULT, APB_DW'(46'h2AAA_AAAA_AAAA));
        send_word(REQ_NEXT, '0);
        send_word(REQ_NEXT, '0);
        send_word(REQ_JUMP, COUNT_W'(7));
        wait_idle();
        write_reg(ADDR_SEED, APB_DW'(314159264));
        send_word(REQ_JUMP, COUNT_W'(2));
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [APB_DW-1:0]  d;
        logic [COUNT_W-1:0] cnt;
        logic               req;
        int                 len;
        wait_idle();
        write_reg(ADDR_SEED, {$urandom, $urandom});
        d = {$urandom, $urandom};
        case ($urandom_range(9))
            0: d[MOD_W-1:0] = '1;
            1: d[MOD_W-1:0] = MOD_W'(1);
            default: if ($urandom_range(9) < 7) d[0] = 1'b1;
        endcase
        write_reg(ADDR_MULT, d);
        repeat (n_items) begin
            req = ($urandom_range(3) == 0) ? REQ_JUMP : REQ_NEXT;
            cnt = COUNT_W'({$urandom, $urandom});
            // Long jumps are slow, so most counts are kept short.
            if ($urandom_range(99) >= 15) begin
                len = $urandom_range(12);
                cnt = cnt & ((COUNT_W'(1) << len) - 1'b1);
            end
            send_word(req, cnt);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 30;
        rx_idle_pct = 56;
        test_reset_state();
        test_jump_edges();
        test_config_extremes();
        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 56;
                end
                1: begin
                    tx_idle_pct = 56;
                    rx_idle_pct = 30;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (4) test_random_traffic(59);
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
